@@ hdl/lrd_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the log record deframer.
// No dependencies; used by log_record_deframer_crc32 through scoped names.
package lrd_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_RESET = 32'h4153_5452;

    // Header byte counts at which each header word is complete
    localparam logic [3:0] MAGIC_DONE  = 4'd4;
    localparam logic [3:0] CRC_DONE    = 4'd8;
    localparam logic [3:0] HEADER_DONE = 4'd12;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        K_BYTE     = 3'd0,
        K_GOOD     = 3'd1,
        K_CRCBAD   = 3'd2,
        K_MAGICBAD = 3'd3,
        K_TORN     = 3'd4,
        K_END      = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] record_length;
        logic        last_of_run;
    } t_result;

    // Reflected CRC-32 register update for one byte, bitwise form
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] x;
        x = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

@@ hdl/log_record_deframer_crc32.sv @@
// Log record deframer with CRC-32 payload check, top level.
// Depends on lrd_pkg for types, constants and the CRC byte update.

// Takes one stream byte per cycle, unless the input stalls, and splits the
// stream into records of a 12-byte little-endian header (magic word, CRC-32,
// payload length) and payload. Payload bytes come out as they arrive; after
// the last one a verdict word (good or CRC mismatch) follows. Bad magic or a
// CRC mismatch halts the block until the end-of-stream word, which reports a
// torn record if one is open and then a stream end, and returns the block to
// its reset state (the magic register keeps its value). Each input word passes
// an input register and then the CRC/compare logic, which writes its results
// into a 4-entry queue once the queue has room; results leave the queue one per
// cycle while the consumer is ready, so a word with two results (last payload
// byte, or a torn record at end of stream) takes two queue entries. The input
// stalls only while the queue holds more than two results. Write the magic
// register only while the block is idle.
module log_record_deframer_crc32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_record_length,
    output logic        o_last_of_run
);

    logic [31:0]   r_magic;

    logic          r_in_valid;
    logic          r_in_type;
    logic [7:0]    r_in_byte;

    lrd_pkg::t_phase r_phase, n_phase;
    logic [3:0]    r_hdr_cnt, n_hdr_cnt;
    logic [31:0]   r_hdr_word, n_hdr_word;
    logic [31:0]   r_exp_crc, n_exp_crc;
    logic [31:0]   r_pay_len, n_pay_len;
    logic [31:0]   r_left, n_left;
    logic [31:0]   r_crc, n_crc;

    lrd_pkg::t_result r_fifo [lrd_pkg::FIFO_DEPTH];
    logic [lrd_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [lrd_pkg::FIFO_CW-1:0] r_count;

    lrd_pkg::t_result res0, res1;
    logic [1:0]    res_cnt;
    logic          stage_go;
    logic          pop;
    logic [31:0]   shifted;
    logic [3:0]    cnt_inc;
    logic [31:0]   crc_upd;
    logic          torn;

    // Process the held word only when the queue has room for two results
    assign stage_go   = r_in_valid
                        && (r_count <= lrd_pkg::FIFO_CW'(lrd_pkg::FIFO_DEPTH - 2));
    assign o_in_ready = !r_in_valid || stage_go;

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);

    assign o_kind          = r_fifo[r_rd_ptr].kind;
    assign o_payload_byte  = r_fifo[r_rd_ptr].payload_byte;
    assign o_record_length = r_fifo[r_rd_ptr].record_length;
    assign o_last_of_run   = r_fifo[r_rd_ptr].last_of_run;

    assign shifted = {r_in_byte, r_hdr_word[31:8]};
    assign cnt_inc = r_hdr_cnt + 4'd1;
    assign crc_upd = lrd_pkg::crc32_byte(r_crc, r_in_byte);
    assign torn    = (r_phase == lrd_pkg::PH_PAYLOAD)
                     || ((r_phase == lrd_pkg::PH_HEADER) && (r_hdr_cnt != 4'd0));

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_hdr_word = r_hdr_word;
        n_exp_crc  = r_exp_crc;
        n_pay_len  = r_pay_len;
        n_left     = r_left;
        n_crc      = r_crc;
        res0       = '0;
        res1       = '0;
        res_cnt    = 2'd0;

        if (r_in_type) begin
            if (torn) begin
                res0.kind          = lrd_pkg::K_TORN;
                res0.record_length = (r_phase == lrd_pkg::PH_PAYLOAD) ? r_pay_len : 32'd0;
                res1.kind          = lrd_pkg::K_END;
                res1.last_of_run   = 1'b1;
                res_cnt            = 2'd2;
            end else begin
                res0.kind        = lrd_pkg::K_END;
                res0.last_of_run = 1'b1;
                res_cnt          = 2'd1;
            end
            n_phase    = lrd_pkg::PH_HEADER;
            n_hdr_cnt  = 4'd0;
            n_hdr_word = 32'd0;
            n_exp_crc  = 32'd0;
            n_pay_len  = 32'd0;
            n_left     = 32'd0;
            n_crc      = lrd_pkg::ALL_ONES;
        end else begin
            case (r_phase)
                lrd_pkg::PH_HEADER: begin
                    n_hdr_word = shifted;
                    n_hdr_cnt  = cnt_inc;
                    if (cnt_inc == lrd_pkg::MAGIC_DONE) begin
                        if (shifted != r_magic) begin
                            res0.kind        = lrd_pkg::K_MAGICBAD;
                            res0.last_of_run = 1'b1;
                            res_cnt          = 2'd1;
                            n_phase          = lrd_pkg::PH_HALTED;
                            n_hdr_cnt        = 4'd0;
                        end
                    end else if (cnt_inc == lrd_pkg::CRC_DONE) begin
                        n_exp_crc = shifted;
                    end else if (cnt_inc >= lrd_pkg::HEADER_DONE) begin
                        n_pay_len = shifted;
                        n_left    = shifted;
                        n_crc     = lrd_pkg::ALL_ONES;
                        n_hdr_cnt = 4'd0;
                        if (shifted == 32'd0) begin
                            // Empty payload: CRC of nothing is zero
                            res0.kind          = (r_exp_crc == 32'd0) ? lrd_pkg::K_GOOD
                                                                      : lrd_pkg::K_CRCBAD;
                            res0.record_length = shifted;
                            res0.last_of_run   = 1'b1;
                            res_cnt            = 2'd1;
                            n_phase            = (r_exp_crc == 32'd0) ? lrd_pkg::PH_HEADER
                                                                      : lrd_pkg::PH_HALTED;
                        end else begin
                            n_phase = lrd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                lrd_pkg::PH_PAYLOAD: begin
                    res0.kind          = lrd_pkg::K_BYTE;
                    res0.payload_byte  = r_in_byte;
                    res0.record_length = r_pay_len;
                    n_left             = r_left - 32'd1;
                    if (r_left == 32'd1) begin
                        // Last payload byte: byte, then the verdict
                        res1.kind          = ((crc_upd ^ lrd_pkg::ALL_ONES) == r_exp_crc)
                                             ? lrd_pkg::K_GOOD : lrd_pkg::K_CRCBAD;
                        res1.record_length = r_pay_len;
                        res1.last_of_run   = 1'b1;
                        res_cnt            = 2'd2;
                        n_phase            = ((crc_upd ^ lrd_pkg::ALL_ONES) == r_exp_crc)
                                             ? lrd_pkg::PH_HEADER : lrd_pkg::PH_HALTED;
                        n_hdr_cnt          = 4'd0;
                        n_crc              = lrd_pkg::ALL_ONES;
                    end else begin
                        res0.last_of_run = 1'b1;
                        res_cnt          = 2'd1;
                        n_crc            = crc_upd;
                    end
                end
                default: begin
                    // Halted: drop data bytes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= lrd_pkg::MAGIC_RESET;
        end else if (i_cfg_we) begin
            r_magic <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_type <= i_req_type;
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lrd_pkg::PH_HEADER;
            r_hdr_cnt  <= 4'd0;
            r_hdr_word <= 32'd0;
            r_exp_crc  <= 32'd0;
            r_pay_len  <= 32'd0;
            r_left     <= 32'd0;
            r_crc      <= lrd_pkg::ALL_ONES;
        end else if (stage_go) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_hdr_word <= n_hdr_word;
            r_exp_crc  <= n_exp_crc;
            r_pay_len  <= n_pay_len;
            r_left     <= n_left;
            r_crc      <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go && (res_cnt != 2'd0)) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (stage_go && (res_cnt == 2'd2)) begin
            r_fifo[r_wr_ptr + lrd_pkg::FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (stage_go) begin
                r_wr_ptr <= r_wr_ptr + lrd_pkg::FIFO_AW'(res_cnt);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + lrd_pkg::FIFO_AW'(1);
            end
            r_count <= r_count
                       + (stage_go ? lrd_pkg::FIFO_CW'(res_cnt) : lrd_pkg::FIFO_CW'(0))
                       - lrd_pkg::FIFO_CW'(pop);
        end
    end

endmodule
